>>> design/rtc_count_calendar_convert_assert.svh
// Assertion macros for the seconds counter / calendar converter.
// Used by the port checker; no dependencies.
`ifndef RTC_COUNT_CALENDAR_CONVERT_ASSERT_SVH
`define RTC_COUNT_CALENDAR_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RTC_CC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RTC_CC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rtc_cc_pkg.sv
// Shared types, constants and helper functions of the counter / calendar converter.
// No dependencies; used by every module of the block.
package rtc_cc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_REF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_US   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UTC_OFF   = 2'd3;
  localparam logic [31:0] TICK_US_RESET = 32'd1000000;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 80;

  // 10^6 = 2^6 * 15625: shift first, then restoring division by 15625
  localparam logic [14:0] DIV_D      = 15'd15625;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_FIRST  = 2;
  localparam int unsigned DIV_LAST   = 16;
  localparam int unsigned FRONT_STAGES = 18;
  localparam int unsigned CAL_STAGES   = 9;

  // Reciprocal constants: floor(x/D) = (x*M) >> K, exact for the stated x range
  localparam int unsigned K_DAY   = 35;  // x < 2^25, D = 675
  localparam logic [31:0] M_DAY   = 32'(((64'd1 << K_DAY) + 64'd674) / 64'd675);
  localparam int unsigned K_S60   = 23;  // x < 2^17
  localparam logic [31:0] M_S60   = 32'(((64'd1 << K_S60) + 64'd59) / 64'd60);
  localparam int unsigned K_H60   = 17;  // x < 2^11
  localparam logic [31:0] M_H60   = 32'(((64'd1 << K_H60) + 64'd59) / 64'd60);
  localparam int unsigned K_W7    = 19;  // x < 2^16
  localparam logic [31:0] M_W7    = 32'(((64'd1 << K_W7) + 64'd6) / 64'd7);
  localparam int unsigned K_Y1460 = 29;  // x < 2^18
  localparam logic [31:0] M_Y1460 = 32'(((64'd1 << K_Y1460) + 64'd1459) / 64'd1460);
  localparam int unsigned K_Y365  = 27;  // x < 2^18
  localparam logic [31:0] M_Y365  = 32'(((64'd1 << K_Y365) + 64'd364) / 64'd365);
  localparam int unsigned K_Y100  = 16;  // x < 2^9
  localparam logic [31:0] M_Y100  = 32'(((64'd1 << K_Y100) + 64'd99) / 64'd100);
  localparam int unsigned K_M153  = 19;  // x < 2^11
  localparam logic [31:0] M_M153  = 32'(((64'd1 << K_M153) + 64'd152) / 64'd153);
  localparam int unsigned K_D5    = 14;  // x < 2^11
  localparam logic [31:0] M_D5    = 32'(((64'd1 << K_D5) + 64'd4) / 64'd5);
  localparam int unsigned K_Y400  = 22;  // x < 2^13
  localparam logic [31:0] M_Y400  = 32'(((64'd1 << K_Y400) + 64'd399) / 64'd400);

  typedef struct packed {
    logic        calib_en;
    logic [31:0] cal_ref;
    logic [31:0] tick;
    logic [4:0]  offset;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_t;

  typedef struct packed {
    logic [59:0] dvd;
    logic [13:0] rem;
    logic [31:0] quo;
  } div_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] cnt;
    logic [31:0] diff;
    logic [63:0] prod;
    div_t        dv;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [12:0] yp;
    logic [3:0]  midx;
    logic [31:0] hms;
    logic [3:0]  yq;
    logic [8:0]  yoe;
    logic [17:0] ed;
    logic [31:0] ocnt;
  } front_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] t;
    logic [31:0] ocnt;
  } fo_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] t;
    logic [31:0] ocnt;
    logic [15:0] dq;
    logic [16:0] rem;
    logic        era;
    logic [17:0] doe;
    logic [15:0] days3;
    logic [10:0] mq;
    logic [6:0]  a;
    logic [2:0]  b;
    logic        c;
    logic [12:0] wq;
    logic [5:0]  sec;
    logic [4:0]  hr;
    logic [17:0] t2;
    logic [2:0]  wd;
    logic [5:0]  mn;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [10:0] u;
    logic [3:0]  mon;
    logic [11:0] yr;
    logic [4:0]  dd;
  } cal_t;

  typedef struct packed {
    logic [31:0] count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } out_t;

  function automatic logic [31:0] mul_shr(input logic [31:0] x, input logic [31:0] m,
                                          input int unsigned k);
    logic [63:0] p;
    p = 64'(x) * 64'(m);
    return 32'(p >> k);
  endfunction

  // Four restoring steps of the division by 15625
  function automatic div_t div_step4(input div_t s);
    div_t        r;
    logic [14:0] w;
    r = s;
    for (int b = 0; b < DIV_STEPS; b++) begin
      w     = {r.rem, r.dvd[59]};
      r.dvd = {r.dvd[58:0], 1'b0};
      if (w >= DIV_D) begin
        r.rem = 14'(w - DIV_D);
        r.quo = {r.quo[30:0], 1'b1};
      end else begin
        r.rem = w[13:0];
        r.quo = {r.quo[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Signed hour offset to seconds, modulo 2^32
  function automatic logic [31:0] off_secs(input logic [4:0] o);
    logic [31:0] s;
    s = {{27{o[4]}}, o};
    return s * 32'd3600;
  endfunction

  // Day of a March-based year at which month index mi starts
  function automatic logic [8:0] doy_of(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/rtc_cc_front.sv
// Front pipeline: drift correction (multiply, divide by 10^6), time zone offset,
// and the complete calendar-to-count path. Depends on rtc_cc_pkg.
module rtc_cc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtc_cc_pkg::cfg_t   cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtc_cc_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtc_cc_pkg::fo_t    out_data_o
);

  localparam int unsigned N = rtc_cc_pkg::FRONT_STAGES;

  rtc_cc_pkg::front_t stg_q [N];
  rtc_cc_pkg::front_t stg_d [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] vld_in;
  logic [N-1:0] stage_rdy;

  assign vld_in = {vld_q[N-2:0], in_valid_i};
  assign stage_rdy[N-1] = !vld_q[N-1] || out_ready_i;

  for (genvar g = 0; g < N - 1; g++) begin : g_rdy
    assign stage_rdy[g] = !vld_q[g] || stage_rdy[g+1];
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (stage_rdy[g]) begin
        vld_q[g] <= vld_in[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (stage_rdy[g]) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  always_comb begin
    rtc_cc_pkg::div_t  dinit;
    logic [3:0]        mo;
    logic [31:0]       yq100;

    // stage 0: capture, subtract reference
    stg_d[0]        = '0;
    stg_d[0].kind   = in_data_i.kind;
    stg_d[0].cnt    = in_data_i.count;
    stg_d[0].diff   = in_data_i.count - cfg_i.cal_ref;
    stg_d[0].year   = in_data_i.year;
    stg_d[0].month  = in_data_i.month;
    stg_d[0].day    = in_data_i.day;
    stg_d[0].hour   = in_data_i.hour;
    stg_d[0].minute = in_data_i.minute;
    stg_d[0].second = in_data_i.second;

    for (int i = 1; i < N; i++) begin
      stg_d[i] = stg_q[i-1];
    end

    // stage 1: elapsed ticks times tick length
    stg_d[1].prod = 64'(stg_q[0].diff) * 64'(cfg_i.tick);

    // division stages
    dinit.dvd = {2'b00, stg_q[1].prod[63:6]};
    dinit.rem = '0;
    dinit.quo = '0;
    stg_d[rtc_cc_pkg::DIV_FIRST].dv = rtc_cc_pkg::div_step4(dinit);
    for (int i = rtc_cc_pkg::DIV_FIRST + 1; i <= rtc_cc_pkg::DIV_LAST; i++) begin
      stg_d[i].dv = rtc_cc_pkg::div_step4(stg_q[i-1].dv);
    end

    // calendar to count, alongside the divider
    // stage 2: fold out-of-range months, March-based year biased by 400
    if (stg_q[1].month == 4'd0) begin
      mo = 4'd12;
    end else if (stg_q[1].month > 4'd12) begin
      mo = stg_q[1].month - 4'd12;
    end else begin
      mo = stg_q[1].month;
    end
    stg_d[2].yp   = 13'(stg_q[1].year) + 13'd400 - 13'(stg_q[1].month == 4'd0)
                  + 13'(stg_q[1].month > 4'd12) - 13'(mo <= 4'd2);
    stg_d[2].midx = (mo > 4'd2) ? mo - 4'd3 : mo + 4'd9;
    stg_d[2].hms  = 32'(stg_q[1].hour) * 32'd3600 + 32'(stg_q[1].minute) * 32'd60
                  + 32'(stg_q[1].second) - rtc_cc_pkg::off_secs(cfg_i.offset);

    // stage 3: 400-year cycle index (one above the era)
    stg_d[3].yq = 4'(rtc_cc_pkg::mul_shr(32'(stg_q[2].yp), rtc_cc_pkg::M_Y400,
                                         rtc_cc_pkg::K_Y400));
    // stage 4: year of cycle
    stg_d[4].yoe = 9'(stg_q[3].yp - 13'(stg_q[3].yq) * 13'd400);
    // stage 5: day of cycle
    yq100 = rtc_cc_pkg::mul_shr(32'(stg_q[4].yoe), rtc_cc_pkg::M_Y100, rtc_cc_pkg::K_Y100);
    stg_d[5].ed = 18'(32'(stg_q[4].yoe) * 32'd365 + 32'(stg_q[4].yoe[8:2]) - yq100
                      + 32'(rtc_cc_pkg::doy_of(stg_q[4].midx)));
    // stage 6: days since epoch
    stg_d[6].ocnt = 32'(stg_q[5].yq) * 32'd146097 + 32'(stg_q[5].ed) + 32'(stg_q[5].day)
                  - 32'd1 - 32'd146097 - 32'd719468;
    // stage 7: seconds
    stg_d[7].ocnt = stg_q[6].ocnt * 32'd86400 + stg_q[6].hms;

    // last stage: corrected count plus zone offset
    stg_d[N-1].cnt = (cfg_i.calib_en ? cfg_i.cal_ref + stg_q[N-2].dv.quo : stg_q[N-2].cnt)
                   + rtc_cc_pkg::off_secs(cfg_i.offset);
  end

  assign in_ready_o      = stage_rdy[0];
  assign out_valid_o     = vld_q[N-1];
  assign out_data_o.kind = stg_q[N-1].kind;
  assign out_data_o.t    = stg_q[N-1].cnt;
  assign out_data_o.ocnt = stg_q[N-1].ocnt;

endmodule

>>> design/rtc_cc_cal.sv
// Calendar pipeline: splits a local seconds count into date, time and weekday,
// and forms the final result word. Depends on rtc_cc_pkg.
module rtc_cc_cal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtc_cc_pkg::fo_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtc_cc_pkg::out_t   out_data_o
);

  localparam int unsigned N = rtc_cc_pkg::CAL_STAGES;

  rtc_cc_pkg::cal_t stg_q [N];
  rtc_cc_pkg::cal_t stg_d [N];
  logic [N-1:0] vld_q;
  logic [N-1:0] vld_in;
  logic [N-1:0] stage_rdy;

  assign vld_in = {vld_q[N-2:0], in_valid_i};
  assign stage_rdy[N-1] = !vld_q[N-1] || out_ready_i;

  for (genvar g = 0; g < N - 1; g++) begin : g_rdy
    assign stage_rdy[g] = !vld_q[g] || stage_rdy[g+1];
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (stage_rdy[g]) begin
        vld_q[g] <= vld_in[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (stage_rdy[g]) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  always_comb begin
    logic [31:0] y100;
    logic [3:0]  mon;

    // stage 0: day number, t/86400 = (t>>7)/675
    stg_d[0]      = '0;
    stg_d[0].kind = in_data_i.kind;
    stg_d[0].t    = in_data_i.t;
    stg_d[0].ocnt = in_data_i.ocnt;
    stg_d[0].dq   = 16'(rtc_cc_pkg::mul_shr(32'(in_data_i.t[31:7]), rtc_cc_pkg::M_DAY,
                                            rtc_cc_pkg::K_DAY));

    for (int i = 1; i < N; i++) begin
      stg_d[i] = stg_q[i-1];
    end

    // stage 1: seconds of day, day of 400-year cycle (era is 4 or 5 here)
    stg_d[1].rem   = 17'(stg_q[0].t - 32'(stg_q[0].dq) * 32'd86400);
    stg_d[1].era   = stg_q[0].dq >= 16'd11017;
    stg_d[1].doe   = 18'(32'(stg_q[0].dq) + 32'd719468
                         - ((stg_q[0].dq >= 16'd11017) ? 32'd730485 : 32'd584388));
    stg_d[1].days3 = stg_q[0].dq + 16'd3;

    // stage 2
    stg_d[2].mq = 11'(rtc_cc_pkg::mul_shr(32'(stg_q[1].rem), rtc_cc_pkg::M_S60,
                                          rtc_cc_pkg::K_S60));
    stg_d[2].a  = 7'(rtc_cc_pkg::mul_shr(32'(stg_q[1].doe), rtc_cc_pkg::M_Y1460,
                                         rtc_cc_pkg::K_Y1460));
    stg_d[2].b  = 3'(stg_q[1].doe >= 18'd36524) + 3'(stg_q[1].doe >= 18'd73048)
                + 3'(stg_q[1].doe >= 18'd109572) + 3'(stg_q[1].doe >= 18'd146096);
    stg_d[2].c  = stg_q[1].doe == 18'd146096;
    stg_d[2].wq = 13'(rtc_cc_pkg::mul_shr(32'(stg_q[1].days3), rtc_cc_pkg::M_W7,
                                          rtc_cc_pkg::K_W7));

    // stage 3
    stg_d[3].sec = 6'(stg_q[2].rem - 17'(stg_q[2].mq) * 17'd60);
    stg_d[3].hr  = 5'(rtc_cc_pkg::mul_shr(32'(stg_q[2].mq), rtc_cc_pkg::M_H60,
                                          rtc_cc_pkg::K_H60));
    stg_d[3].t2  = stg_q[2].doe - 18'(stg_q[2].a) + 18'(stg_q[2].b) - 18'(stg_q[2].c);
    stg_d[3].wd  = 3'(stg_q[2].days3 - 16'(stg_q[2].wq) * 16'd7);

    // stage 4
    stg_d[4].mn  = 6'(stg_q[3].mq - 11'(stg_q[3].hr) * 11'd60);
    stg_d[4].yoe = 9'(rtc_cc_pkg::mul_shr(32'(stg_q[3].t2), rtc_cc_pkg::M_Y365,
                                          rtc_cc_pkg::K_Y365));

    // stage 5: day of March-based year
    y100 = rtc_cc_pkg::mul_shr(32'(stg_q[4].yoe), rtc_cc_pkg::M_Y100, rtc_cc_pkg::K_Y100);
    stg_d[5].doy = 9'(32'(stg_q[4].doe) - (32'(stg_q[4].yoe) * 32'd365
                      + 32'(stg_q[4].yoe[8:2]) - y100));

    // stage 6: month index from March
    stg_d[6].mp = 4'(rtc_cc_pkg::mul_shr(32'(stg_q[5].doy) * 32'd5 + 32'd2,
                                         rtc_cc_pkg::M_M153, rtc_cc_pkg::K_M153));

    // stage 7
    mon = (stg_q[6].mp < 4'd10) ? stg_q[6].mp + 4'd3 : stg_q[6].mp - 4'd9;
    stg_d[7].u   = 11'(32'(stg_q[6].mp) * 32'd153 + 32'd2);
    stg_d[7].mon = mon;
    stg_d[7].yr  = 12'(32'(stg_q[6].yoe) + (stg_q[6].era ? 32'd2000 : 32'd1600)
                       + 32'(mon <= 4'd2));

    // stage 8: day of month, select result by kind
    stg_d[8].dd = 5'(32'(stg_q[7].doy) - rtc_cc_pkg::mul_shr(32'(stg_q[7].u),
                     rtc_cc_pkg::M_D5, rtc_cc_pkg::K_D5) + 32'd1);
    if (stg_q[7].kind) begin
      stg_d[8].yr  = '0;
      stg_d[8].mon = '0;
      stg_d[8].dd  = '0;
      stg_d[8].hr  = '0;
      stg_d[8].mn  = '0;
      stg_d[8].sec = '0;
      stg_d[8].wd  = '0;
    end else begin
      stg_d[8].ocnt = '0;
    end
  end

  assign in_ready_o          = stage_rdy[0];
  assign out_valid_o         = vld_q[N-1];
  assign out_data_o.count    = stg_q[N-1].ocnt;
  assign out_data_o.year     = stg_q[N-1].yr;
  assign out_data_o.month    = stg_q[N-1].mon;
  assign out_data_o.day      = stg_q[N-1].dd;
  assign out_data_o.hour     = stg_q[N-1].hr;
  assign out_data_o.minute   = stg_q[N-1].mn;
  assign out_data_o.second   = stg_q[N-1].sec;
  assign out_data_o.weekday  = stg_q[N-1].wd;

endmodule

>>> design/rtc_count_calendar_convert.sv
// Seconds counter <-> local calendar converter, top level.
// Depends on rtc_cc_pkg, rtc_cc_front and rtc_cc_cal.
//
// Takes one conversion word per clock while the pipeline has room and returns
// one result word per word, in order. Each word passes 27 register stages on
// its way to the master side: 18 front stages (32x32 drift multiply, then a
// restoring divide by 10^6 that retires four quotient bits per stage over 15
// stages, then the zone offset) and 9 calendar stages (constant-reciprocal
// multiplies and remainder steps). Every stage moves on its own
// when the next one has room, so bubbles are absorbed and a stalled output
// still lets new words in until the pipeline is full. Kind 0 (tuser = 0)
// converts a raw count to a local date and leaves the count field zero;
// kind 1 converts a local date to a UTC count and leaves the date fields
// zero. Registers are written through the plain write port and should only
// change while nothing is in flight.
module rtc_count_calendar_convert (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [rtc_cc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [31:0]                              cfg_data_i,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // in_count, in_year, in_month, in_day, in_hour, in_minute, in_second, zero pad
  input  logic [rtc_cc_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // kind
  input  logic [0:0]                               s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // out_count, out_year, out_month, out_day, out_hour, out_minute, out_second,
  // out_weekday, zero pad
  output logic [rtc_cc_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  rtc_cc_pkg::cfg_t cfg_q;
  rtc_cc_pkg::in_t  in_word;
  rtc_cc_pkg::fo_t  mid_word;
  rtc_cc_pkg::out_t out_word;
  logic             mid_valid;
  logic             mid_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calib_en <= 1'b0;
      cfg_q.cal_ref  <= '0;
      cfg_q.tick     <= rtc_cc_pkg::TICK_US_RESET;
      cfg_q.offset   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtc_cc_pkg::CFG_CALIB_EN:  cfg_q.calib_en <= cfg_data_i[0];
        rtc_cc_pkg::CFG_CALIB_REF: cfg_q.cal_ref  <= cfg_data_i;
        rtc_cc_pkg::CFG_TICK_US:   cfg_q.tick     <= cfg_data_i;
        rtc_cc_pkg::CFG_UTC_OFF:   cfg_q.offset   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_word.kind   = s_axis_tuser[0];
  assign in_word.count  = s_axis_tdata[31:0];
  assign in_word.year   = s_axis_tdata[43:32];
  assign in_word.month  = s_axis_tdata[47:44];
  assign in_word.day    = s_axis_tdata[52:48];
  assign in_word.hour   = s_axis_tdata[57:53];
  assign in_word.minute = s_axis_tdata[63:58];
  assign in_word.second = s_axis_tdata[69:64];

  rtc_cc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_word),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_word)
  );

  rtc_cc_cal u_cal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_word),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_word)
  );

  assign m_axis_tdata = {7'd0, out_word.weekday, out_word.second, out_word.minute,
                         out_word.hour, out_word.day, out_word.month, out_word.year,
                         out_word.count};

endmodule

>>> design/rtc_cc_chk.sv
// Port-level checker for the converter, bound to the top level.
// Depends on rtc_cc_pkg and rtc_count_calendar_convert_assert.svh.
`include "rtc_count_calendar_convert_assert.svh"

module rtc_cc_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rtc_cc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // a stalled result word holds
  `RTC_CC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // a word carries either a count or a calendar date, never both
  `RTC_CC_ASSERT_IMPL(a_kind_excl, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:0] == 32'd0 || m_axis_tdata[79:32] == 48'd0, "count and date both set")

  // calendar fields stay in range
  `RTC_CC_ASSERT_IMPL(a_cal_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[79:32] != 48'd0, m_axis_tdata[47:44] >= 4'd1 && m_axis_tdata[47:44] <= 4'd12 && m_axis_tdata[52:48] >= 5'd1 && m_axis_tdata[57:53] <= 5'd23 && m_axis_tdata[63:58] <= 6'd59 && m_axis_tdata[69:64] <= 6'd59 && m_axis_tdata[72:70] <= 3'd6, "calendar field out of range")

  // date words always carry a year from the counter's span
  `RTC_CC_ASSERT_IMPL(a_year_span, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[79:32] != 48'd0, m_axis_tdata[43:32] >= 12'd1969 && m_axis_tdata[43:32] <= 12'd2106 && m_axis_tdata[79:73] == 7'd0, "year outside counter span")

endmodule

bind rtc_count_calendar_convert rtc_cc_chk u_rtc_cc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_top.sv
// Self-checking bench for the seconds counter / calendar converter.
// Depends on rtc_cc_pkg and rtc_count_calendar_convert; predicts every word in SV.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic        kind;
    logic [31:0] count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    bit          fixed;
    rtc_cc_pkg::out_t res;
  } conv_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [rtc_cc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [31:0]                       cfg_data_i = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [rtc_cc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                        s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rtc_cc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // mirror of the block's registers
  logic        calib_en_q = 1'b0;
  logic [31:0] calib_ref_q = '0;
  logic [31:0] tick_us_q = rtc_cc_pkg::TICK_US_RESET;
  logic [4:0]  utc_off_q = '0;

  rtc_cc_pkg::out_t pending_dates[$];
  bit               cur_fixed = 0;
  rtc_cc_pkg::out_t cur_res;
  int               errors = 0;
  int               send_gap_pct = 0;
  int               recv_stall_pct = 0;
  longint           cycle_cnt = 0;

  rtc_count_calendar_convert u_top (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint days_to_month(longint y, longint m);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic rtc_cc_pkg::out_t convert(logic [rtc_cc_pkg::IN_DATA_W-1:0] d,
                                               logic kind);
    rtc_cc_pkg::out_t r;
    longint      off, y, m, total;
    bit [31:0]   t, days, rem, z, era, doe, yoe, yy, doy, mp, dd, mm, diff;
    bit [63:0]   scaled;
    off = longint'($signed(utc_off_q)) * 3600;
    r = '0;
    if (kind == 1'b0) begin
      t = d[31:0];
      if (calib_en_q) begin
        diff   = t - calib_ref_q;
        scaled = (64'(diff) * 64'(tick_us_q)) / 64'd1000000;
        t      = calib_ref_q + scaled[31:0];
      end
      t    = t + 32'(off);
      days = t / 86400;
      rem  = t % 86400;
      z    = days + 719468;
      era  = z / 146097;
      doe  = z - era * 146097;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yy   = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      dd   = doy - (153 * mp + 2) / 5 + 1;
      mm   = mp < 10 ? mp + 3 : mp - 9;
      if (mm <= 2) yy = yy + 1;
      r.year    = yy[11:0];
      r.month   = mm[3:0];
      r.day     = dd[4:0];
      r.hour    = 5'(rem / 3600);
      r.minute  = 6'((rem / 60) % 60);
      r.second  = 6'(rem % 60);
      r.weekday = 3'((days + 3) % 7);
    end else begin
      y = longint'(d[43:32]);
      m = longint'(d[47:44]);
      if (m == 0) begin
        m = 12;
        y = y - 1;
      end else if (m > 12) begin
        m = m - 12;
        y = y + 1;
      end
      total = (days_to_month(y, m) + d[52:48] - 1) * 86400 + d[57:53] * 3600
            + d[63:58] * 60 + d[69:64] - off;
      r.count = total[31:0];
    end
    return r;
  endfunction

  function automatic logic [rtc_cc_pkg::IN_DATA_W-1:0] pack_item(conv_row_t it);
    return {2'b0, it.second, it.minute, it.hour, it.day, it.month, it.year, it.count};
  endfunction

  task automatic write_reg(logic [rtc_cc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rtc_cc_pkg::CFG_CALIB_EN:  calib_en_q  = val[0];
      rtc_cc_pkg::CFG_CALIB_REF: calib_ref_q = val;
      rtc_cc_pkg::CFG_TICK_US:   tick_us_q   = val;
      rtc_cc_pkg::CFG_UTC_OFF:   utc_off_q   = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic send_word(conv_row_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.kind;
    cur_fixed     <= it.fixed;
    cur_res       <= it.res;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic conv_row_t random_item();
    conv_row_t it;
    int        dim[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    it = '{default: '0};
    it.kind = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       it.count = $urandom_range(200);
      1:       it.count = 32'hFFFF_FFFF - $urandom_range(200);
      default: it.count = $urandom;
    endcase
    if ($urandom_range(99) < 15) begin
      // malformed dates: every bit of every field exercised
      it.year = 12'($urandom); it.month = 4'($urandom); it.day = 5'($urandom);
      it.hour = 5'($urandom); it.minute = 6'($urandom); it.second = 6'($urandom);
    end else begin
      it.year   = 12'($urandom_range(2106, 1970));
      it.month  = 4'($urandom_range(12, 1));
      it.day    = 5'($urandom_range(dim[it.month-1] + ((it.month == 2 && it.year % 4 == 0 &&
                  it.year != 2100) ? 1 : 0), 1));
      it.hour   = 5'($urandom_range(23));
      it.minute = 6'($urandom_range(59));
      it.second = 6'($urandom_range(59));
    end
    return it;
  endfunction

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    rtc_cc_pkg::out_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("Some tests failed");
      $finish;
    end
    if (s_axis_tvalid && s_axis_tready)
      pending_dates.push_back(cur_fixed ? cur_res : convert(s_axis_tdata, s_axis_tuser[0]));
    if (m_axis_tvalid && m_axis_tready) begin
      got.count   = m_axis_tdata[31:0];
      got.year    = m_axis_tdata[43:32];
      got.month   = m_axis_tdata[47:44];
      got.day     = m_axis_tdata[52:48];
      got.hour    = m_axis_tdata[57:53];
      got.minute  = m_axis_tdata[63:58];
      got.second  = m_axis_tdata[69:64];
      got.weekday = m_axis_tdata[72:70];
      if (pending_dates.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        if (got.count != want.count) begin
          $error("out_count exp %0d got %0d", want.count, got.count); errors++;
        end
        if (got.year != want.year) begin
          $error("out_year exp %0d got %0d", want.year, got.year); errors++;
        end
        if (got.month != want.month) begin
          $error("out_month exp %0d got %0d", want.month, got.month); errors++;
        end
        if (got.day != want.day) begin
          $error("out_day exp %0d got %0d", want.day, got.day); errors++;
        end
        if (got.hour != want.hour) begin
          $error("out_hour exp %0d got %0d", want.hour, got.hour); errors++;
        end
        if (got.minute != want.minute) begin
          $error("out_minute exp %0d got %0d", want.minute, got.minute); errors++;
        end
        if (got.second != want.second) begin
          $error("out_second exp %0d got %0d", want.second, got.second); errors++;
        end
        if (got.weekday != want.weekday) begin
          $error("out_weekday exp %0d got %0d", want.weekday, got.weekday); errors++;
        end
      end
    end
  end

  initial begin
    conv_row_t   dir_rows[$];
    conv_row_t   it;
    logic [31:0] refs[4] = '{32'd0, 32'hFFFF_FFFF, 32'd1_500_000_000, 32'd0};
    logic [31:0] ticks[4] = '{32'd1, 32'hFFFF_FFFF, 32'd999_950, 32'd1_000_050};
    logic [4:0]  offs[8] = '{5'd0, -5'sd12, 5'd14, -5'sd16, 5'd15, 5'd1, -5'sd5, 5'd9};
    // count rows: epoch is a Thursday; the top of the counter is a Sunday in 2106
    dir_rows.push_back('{0, 32'd0, 0, 0, 0, 0, 0, 0, 1,
                         '{0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3}});
    dir_rows.push_back('{0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1,
                         '{0, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd6}});
    dir_rows.push_back('{0, 32'd951_782_400, 0, 0, 0, 0, 0, 0, 0, '0});  // 2000 leap day
    dir_rows.push_back('{0, 32'd86_399, 0, 0, 0, 0, 0, 0, 0, '0});
    // date rows
    dir_rows.push_back('{1, 0, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1, '0});
    dir_rows.push_back('{1, 0, 12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 1,
                         '{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0}});
    dir_rows.push_back('{1, 0, 12'd2000, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 0, '0});   // month 0
    dir_rows.push_back('{1, 0, 12'd2000, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 0, '0}); // month 15
    dir_rows.push_back('{1, 0, 12'd2001, 4'd3, 5'd0, 5'd24, 6'd63, 6'd63, 0, '0}); // day 0
    dir_rows.push_back('{1, 0, 12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 0, '0});
    dir_rows.push_back('{1, 0, 12'd4095, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 0, '0});
    dir_rows.push_back('{1, 0, 12'd2100, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rtc_cc_pkg::CFG_CALIB_EN, ph % 2);
      write_reg(rtc_cc_pkg::CFG_CALIB_REF, ph < 4 ? refs[ph] : $urandom);
      write_reg(rtc_cc_pkg::CFG_TICK_US,
                ph < 4 ? ticks[ph] : $urandom_range(1_001_000, 999_000));
      write_reg(rtc_cc_pkg::CFG_UTC_OFF, 32'(offs[ph]));
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 11; recv_stall_pct = 11; end
      endcase
      if (ph < 4 && ph % 2 == 1) begin
        // calibrated phases: a count equal to the reference, where the drift term is zero
        it = '{default: '0};
        it.count = refs[ph];
        send_word(it);
      end
      for (int n = 0; n < 250; n++) begin
        it = random_item();
        send_word(it);
        if (ph == 3 && n == 100) begin
          s_axis_tvalid <= 1'b0;
          while (pending_dates.size() != 0) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> rtc_count_calendar_convert.f
+incdir+design
design/rtc_cc_pkg.sv
design/rtc_cc_front.sv
design/rtc_cc_cal.sv
design/rtc_count_calendar_convert.sv
design/rtc_cc_chk.sv
bench/tb_top.sv
